/* hdl/oile_pkg.sv */
// ----------------------------------------------------------------------------
// Ordered integer list engine package
// Shared widths, command and status codes, and the controller/datapath link.
// ----------------------------------------------------------------------------
package oile_pkg;

    localparam int DEPTH      = 64;
    localparam int WORD_BITS  = 32;

    localparam int CMD_W      = 3;
    localparam int POS_W      = 7;
    localparam int OUT_WORD_W = 32;
    localparam int FPOS_W     = 6;
    localparam int ICNT_W     = 7;
    localparam int ST_W       = 2;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT     = 3'd0,
        CMD_ERASE      = 3'd1,
        CMD_FIND       = 3'd2,
        CMD_READ       = 3'd3,
        CMD_PUSH_BACK  = 3'd4,
        CMD_PUSH_FRONT = 3'd5,
        CMD_POP_BACK   = 3'd6,
        CMD_POP_FRONT  = 3'd7
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        K_INS,
        K_REM,
        K_FIND,
        K_READ
    } t_kind;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CHECK,
        OP_INS_RD,
        OP_INS_WR,
        OP_INS_PUT,
        OP_REM_RD0,
        OP_REM_CAP,
        OP_REM_RD,
        OP_REM_WR,
        OP_REM_END,
        OP_FIND_RD,
        OP_FIND_CMP,
        OP_READ_RD,
        OP_READ_CAP,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_kind kind;
        logic  err;
        logic  ins_more;
        logic  rem_more;
        logic  find_more;
        logic  match;
        logic  out_free;
    } t_dp_stat;

    function automatic t_kind f_kind(input t_cmd cmd);
        t_kind k;
        unique case (cmd)
            CMD_INSERT, CMD_PUSH_BACK, CMD_PUSH_FRONT: k = K_INS;
            CMD_ERASE, CMD_POP_BACK, CMD_POP_FRONT:    k = K_REM;
            CMD_FIND:                                  k = K_FIND;
            default:                                   k = K_READ;
        endcase
        return k;
    endfunction

endpackage

/* hdl/oile_cmd_if.sv */
// ----------------------------------------------------------------------------
// Ordered integer list engine command channel
// Valid/ready channel that carries one list command per transaction.
// ----------------------------------------------------------------------------
interface oile_cmd_if import oile_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic [POS_W-1:0]        position;
    logic signed [OUT_WORD_W-1:0] word;

    modport source (output valid, output cmd, output position, output word, input ready);
    modport sink   (input valid, input cmd, input position, input word, output ready);

endinterface

/* hdl/oile_rsp_if.sv */
// ----------------------------------------------------------------------------
// Ordered integer list engine result channel
// Valid/ready channel that carries one command result per transaction.
// ----------------------------------------------------------------------------
interface oile_rsp_if import oile_pkg::*; ();

    logic                         valid;
    logic                         ready;
    logic signed [OUT_WORD_W-1:0] out_word;
    logic [FPOS_W-1:0]            found_position;
    logic                         found;
    logic [ICNT_W-1:0]            item_count;
    logic [ST_W-1:0]              status;

    modport source (
        output valid, output out_word, output found_position, output found,
        output item_count, output status, input ready
    );
    modport sink (
        input valid, input out_word, input found_position, input found,
        input item_count, input status, output ready
    );

endinterface

/* hdl/oile_ctrl.sv */
// ----------------------------------------------------------------------------
// Ordered integer list engine controller
// Sequences each command through check, shift, scan or read, and result steps.
// ----------------------------------------------------------------------------
module oile_ctrl import oile_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_op   o_op
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_INS_RD,
        S_INS_WR,
        S_REM_RD0,
        S_REM_CAP,
        S_REM_RD,
        S_REM_WR,
        S_FIND_RD,
        S_FIND_CMP,
        S_READ_RD,
        S_READ_CAP,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_op = OP_CHECK;
                if (i_stat.err) begin
                    n_state = S_DONE;
                end else begin
                    unique case (i_stat.kind)
                        K_INS:   n_state = S_INS_RD;
                        K_REM:   n_state = S_REM_RD0;
                        K_FIND:  n_state = S_FIND_RD;
                        default: n_state = S_READ_RD;
                    endcase
                end
            end
            S_INS_RD: begin
                if (i_stat.ins_more) begin
                    o_op    = OP_INS_RD;
                    n_state = S_INS_WR;
                end else begin
                    o_op    = OP_INS_PUT;
                    n_state = S_DONE;
                end
            end
            S_INS_WR: begin
                o_op    = OP_INS_WR;
                n_state = S_INS_RD;
            end
            S_REM_RD0: begin
                o_op    = OP_REM_RD0;
                n_state = S_REM_CAP;
            end
            S_REM_CAP: begin
                o_op    = OP_REM_CAP;
                n_state = S_REM_RD;
            end
            S_REM_RD: begin
                if (i_stat.rem_more) begin
                    o_op    = OP_REM_RD;
                    n_state = S_REM_WR;
                end else begin
                    o_op    = OP_REM_END;
                    n_state = S_DONE;
                end
            end
            S_REM_WR: begin
                o_op    = OP_REM_WR;
                n_state = S_REM_RD;
            end
            S_FIND_RD: begin
                if (i_stat.find_more) begin
                    o_op    = OP_FIND_RD;
                    n_state = S_FIND_CMP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FIND_CMP: begin
                o_op    = OP_FIND_CMP;
                n_state = i_stat.match ? S_DONE : S_FIND_RD;
            end
            S_READ_RD: begin
                o_op    = OP_READ_RD;
                n_state = S_READ_CAP;
            end
            S_READ_CAP: begin
                o_op    = OP_READ_CAP;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_op    = OP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

/* hdl/oile_dpath.sv */
// ----------------------------------------------------------------------------
// Ordered integer list engine datapath
// Entry memory, count, command registers, checks and the result register.
// ----------------------------------------------------------------------------
module oile_dpath import oile_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_op                       i_op,
    output t_dp_stat                     o_stat,
    input  logic [CMD_W-1:0]             i_cmd_code,
    input  logic [POS_W-1:0]             i_position,
    input  logic signed [OUT_WORD_W-1:0] i_word,
    output logic                         o_rsp_valid,
    input  logic                         i_rsp_ready,
    output logic signed [OUT_WORD_W-1:0] o_out_word,
    output logic [FPOS_W-1:0]            o_found_position,
    output logic                         o_found,
    output logic [ICNT_W-1:0]            o_item_count,
    output logic [ST_W-1:0]              o_status
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    t_cmd                 r_cmd;
    logic [POS_W-1:0]     r_pos;
    logic [WORD_BITS-1:0] r_word;
    logic [CNT_W-1:0]     r_count;
    logic [IDX_W-1:0]     r_at;
    logic [IDX_W-1:0]     r_idx;
    t_status              r_status;
    logic [WORD_BITS-1:0] r_rword;
    logic                 r_fnd;
    logic [ADDR_W-1:0]    r_fpos;

    logic                  r_out_valid;
    logic [OUT_WORD_W-1:0] r_out_word;
    logic [FPOS_W-1:0]     r_out_fpos;
    logic                  r_out_found;
    logic [ICNT_W-1:0]     r_out_count;
    t_status               r_out_status;

    t_kind                kind;
    logic [IDX_W-1:0]     pos_x;
    logic [IDX_W-1:0]     cnt_x;
    logic [IDX_W-1:0]     chk_at;
    logic [IDX_W-1:0]     chk_idx;
    t_status              chk_st;
    logic                 out_free;
    logic                 match;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    assign kind     = f_kind(r_cmd);
    assign pos_x    = IDX_W'(r_pos);
    assign cnt_x    = IDX_W'(r_count);
    assign out_free = !r_out_valid || i_rsp_ready;
    assign match    = (r_rdata == r_word);

    always_comb begin
        chk_at = '0;
        chk_st = ST_OK;
        unique case (kind)
            K_INS: begin
                if (r_cmd == CMD_INSERT) begin
                    chk_at = pos_x;
                end else if (r_cmd == CMD_PUSH_BACK) begin
                    chk_at = cnt_x;
                end
                if (chk_at > cnt_x) begin
                    chk_st = ST_BADPOS;
                end else if (cnt_x == IDX_W'(DEPTH)) begin
                    chk_st = ST_FULL;
                end
            end
            K_REM: begin
                if (r_cmd == CMD_ERASE) begin
                    chk_at = pos_x;
                end else if (r_cmd == CMD_POP_BACK) begin
                    chk_at = cnt_x - IDX_W'(1);
                end
                if (cnt_x == '0) begin
                    chk_st = ST_EMPTY;
                end else if (chk_at >= cnt_x) begin
                    chk_st = ST_BADPOS;
                end
            end
            K_FIND: begin
                chk_at = '0;
            end
            default: begin
                chk_at = pos_x;
                if (chk_at >= cnt_x) begin
                    chk_st = ST_BADPOS;
                end
            end
        endcase
        chk_idx = (kind == K_INS) ? cnt_x : chk_at;
    end

    always_comb begin
        o_stat.kind      = kind;
        o_stat.err       = (chk_st != ST_OK);
        o_stat.ins_more  = (r_idx > r_at);
        o_stat.rem_more  = ((r_idx + IDX_W'(1)) < cnt_x);
        o_stat.find_more = (r_idx < cnt_x);
        o_stat.match     = match;
        o_stat.out_free  = out_free;
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx;
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = r_rdata;
        unique case (i_op)
            OP_INS_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_idx - IDX_W'(1);
            end
            OP_INS_WR: begin
                wr_en = 1'b1;
            end
            OP_INS_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_at;
                wr_data = r_word;
            end
            OP_REM_RD0, OP_READ_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_at;
            end
            OP_REM_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_idx + IDX_W'(1);
            end
            OP_REM_WR: begin
                wr_en = 1'b1;
            end
            OP_FIND_RD: begin
                rd_en = 1'b1;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr[ADDR_W-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_op == OP_INS_PUT) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_op == OP_REM_END) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD: begin
                r_cmd   <= t_cmd'(i_cmd_code);
                r_pos   <= i_position;
                r_word  <= WORD_BITS'($unsigned(i_word));
                r_rword <= '0;
                r_fnd   <= 1'b0;
                r_fpos  <= '0;
            end
            OP_CHECK: begin
                r_at     <= chk_at;
                r_idx    <= chk_idx;
                r_status <= chk_st;
            end
            OP_INS_WR: begin
                r_idx <= r_idx - IDX_W'(1);
            end
            OP_REM_WR: begin
                r_idx <= r_idx + IDX_W'(1);
            end
            OP_REM_CAP, OP_READ_CAP: begin
                r_rword <= r_rdata;
            end
            OP_FIND_CMP: begin
                if (match) begin
                    r_fnd  <= 1'b1;
                    r_fpos <= r_idx[ADDR_W-1:0];
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            OP_EMIT: begin
                r_out_word   <= OUT_WORD_W'(r_rword);
                r_out_fpos   <= FPOS_W'(r_fpos);
                r_out_found  <= r_fnd;
                r_out_count  <= ICNT_W'(r_count);
                r_out_status <= r_status;
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    assign o_rsp_valid      = r_out_valid;
    assign o_out_word       = $signed(r_out_word);
    assign o_found_position = r_out_fpos;
    assign o_found          = r_out_found;
    assign o_item_count     = r_out_count;
    assign o_status         = r_out_status;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("Entry count exceeds the list depth.");

    a_put_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_INS_PUT) |-> (r_count < CNT_W'(DEPTH)))
        else $error("Insert committed on a full list.");

    a_remove_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_REM_END) |-> (r_count != '0))
        else $error("Removal committed on an empty list.");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_found) |-> (r_out_status == ST_OK))
        else $error("Match reported together with an error status.");

    a_error_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_EMIT && r_status != ST_OK) |=> (r_out_count == ICNT_W'(r_count)))
        else $error("Failed command changed the entry count.");
`endif

endmodule

/* hdl/ordered_int_list_engine_unit.sv */
// Insert and push shift later entries up, a read and a write step each; erase and
// pop capture the removed entry, then shift later entries down the same way; read
// captures one entry; find compares from the head until a hit or the end; errors go
// straight to the result. One command is in work at a time; the result waits for a
// free result register, and a new command can be taken once that result is valid.
// Reset clears the count and the handshakes; entry contents are not cleared.
// ----------------------------------------------------------------------------
// Ordered integer list engine
// Shift-array list of signed words with insert, erase, find, read, push, pop.
// ----------------------------------------------------------------------------
module ordered_int_list_engine_unit import oile_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    oile_cmd_if.sink    i_cmd,
    oile_rsp_if.source  o_rsp
);

    t_dp_op   op;
    t_dp_stat stat;
    logic     in_ready;

    oile_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_op       (op)
    );

    oile_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .o_stat           (stat),
        .i_cmd_code       (i_cmd.cmd),
        .i_position       (i_cmd.position),
        .i_word           (i_cmd.word),
        .o_rsp_valid      (o_rsp.valid),
        .i_rsp_ready      (o_rsp.ready),
        .o_out_word       (o_rsp.out_word),
        .o_found_position (o_rsp.found_position),
        .o_found          (o_rsp.found),
        .o_item_count     (o_rsp.item_count),
        .o_status         (o_rsp.status)
    );

    assign i_cmd.ready = in_ready;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered integer list engine testbench
// Sends list commands through the command channel with random idle gaps,
// tracks the list in a local model of its own, and compares every result
// field by field against the model while the result side stalls at random.
// ----------------------------------------------------------------------------
module testbench;
    import oile_pkg::*;

    localparam int RANDOM_CMDS = 1100;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 200;

    typedef struct packed {
        t_cmd                         cmd;
        logic [POS_W-1:0]             position;
        logic signed [OUT_WORD_W-1:0] word;
    } t_list_cmd;

    typedef struct packed {
        logic signed [OUT_WORD_W-1:0] out_word;
        logic [FPOS_W-1:0]            found_position;
        logic                         found;
        logic [ICNT_W-1:0]            item_count;
        t_status                      status;
    } t_list_rsp;

    logic i_clk;
    logic i_rst_n;

    oile_cmd_if cmd_ch ();
    oile_rsp_if rsp_ch ();

    ordered_int_list_engine_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    t_list_cmd pending_cmds[$];
    t_list_rsp due_results[$];

    logic signed [WORD_BITS-1:0] list_words [DEPTH];
    int list_len = 0;
    int plan_len = 0;
    int mismatch_count = 0;
    int stall_cycles = 0;

    t_list_cmd drv_item;
    bit drv_busy = 1'b0;
    bit drv_quiet = 1'b0;
    int drv_gap = 0;
    bit mon_quiet = 1'b0;
    int rdy_gap = 0;
    t_list_rsp exp_rsp;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int draw_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_word();
        if ($urandom_range(0, 99) >= 60) return $urandom;
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h0000_0001;
            5: return 32'h5555_5555;
            6: return 32'hAAAA_AAAA;
            default: return 32'h0000_002A;
        endcase
    endfunction

    function automatic int pick_pos(input bit for_insert);
        if ($urandom_range(0, 9) == 0 || (!for_insert && plan_len == 0))
            return $urandom_range(0, 127);
        return for_insert ? $urandom_range(0, plan_len) : $urandom_range(0, plan_len - 1);
    endfunction

    // The planned length only steers the stimulus toward full and empty lists.
    task automatic add_cmd(input t_cmd c, input int pos, input logic [31:0] w);
        t_list_cmd it;
        int at;
        it.cmd = c;
        it.position = pos[POS_W-1:0];
        it.word = w;
        pending_cmds = {pending_cmds, it};
        case (c)
            CMD_INSERT, CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                at = (c == CMD_INSERT) ? int'(it.position) : (c == CMD_PUSH_BACK ? plan_len : 0);
                if (at <= plan_len && plan_len < DEPTH) plan_len++;
            end
            CMD_ERASE, CMD_POP_BACK, CMD_POP_FRONT: begin
                at = (c == CMD_ERASE) ? int'(it.position) : (c == CMD_POP_BACK ? plan_len - 1 : 0);
                if (plan_len > 0 && at < plan_len) plan_len--;
            end
            default: ;
        endcase
    endtask

    task automatic apply_list_cmd(input t_list_cmd it);
        t_list_rsp r;
        int at;
        r = '0;
        r.status = ST_OK;
        case (it.cmd)
            CMD_INSERT, CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                at = (it.cmd == CMD_INSERT) ? int'(it.position) :
                     (it.cmd == CMD_PUSH_BACK ? list_len : 0);
                if (at > list_len) begin
                    r.status = ST_BADPOS;
                end else if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = list_len; i > at; i--) list_words[i] = list_words[i-1];
                    list_words[at] = it.word;
                    list_len++;
                end
            end
            CMD_ERASE, CMD_POP_BACK, CMD_POP_FRONT: begin
                at = (it.cmd == CMD_ERASE) ? int'(it.position) :
                     (it.cmd == CMD_POP_BACK ? list_len - 1 : 0);
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (at >= list_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.out_word = list_words[at];
                    for (int i = at; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            CMD_FIND: begin
                for (int i = 0; i < list_len; i++) begin
                    if (!r.found && list_words[i] == it.word) begin
                        r.found = 1'b1;
                        r.found_position = i[FPOS_W-1:0];
                    end
                end
            end
            default: begin
                if (int'(it.position) >= list_len) r.status = ST_BADPOS;
                else r.out_word = list_words[it.position];
            end
        endcase
        r.item_count = list_len[ICNT_W-1:0];
        due_results = {due_results, r};
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
            drv_busy = 1'b0;
            drv_gap = 0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                apply_list_cmd(drv_item);
                drv_busy = 1'b0;
                if ($urandom_range(0, 63) == 0) drv_quiet = !drv_quiet;
                drv_gap = draw_gap(drv_quiet);
            end
            if (!drv_busy) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                end else if (pending_cmds.size() > 0) begin
                    drv_item = pending_cmds[0];
                    pending_cmds.delete(0);
                    drv_busy = 1'b1;
                    cmd_ch.cmd <= drv_item.cmd;
                    cmd_ch.position <= drv_item.position;
                    cmd_ch.word <= drv_item.word;
                end
            end
            cmd_ch.valid <= drv_busy;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            rdy_gap = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual word %h count %0d",
                             $time, rsp_ch.out_word, rsp_ch.item_count);
                    mismatch_count++;
                end else begin
                    exp_rsp = due_results[0];
                    due_results.delete(0);
                    check_field("out_word", exp_rsp.out_word, rsp_ch.out_word);
                    check_field("found_position", 32'(exp_rsp.found_position),
                                32'(rsp_ch.found_position));
                    check_field("found", 32'(exp_rsp.found), 32'(rsp_ch.found));
                    check_field("item_count", 32'(exp_rsp.item_count), 32'(rsp_ch.item_count));
                    check_field("status", 32'(exp_rsp.status), 32'(rsp_ch.status));
                end
                if ($urandom_range(0, 63) == 0) mon_quiet = !mon_quiet;
                rdy_gap = draw_gap(mon_quiet);
            end
            if (rdy_gap > 0) begin
                rdy_gap--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        bit grow;
        int edge_hits;
        int r;
        t_cmd c;

        cmd_ch.valid = 1'b0;
        cmd_ch.cmd = CMD_INSERT;
        cmd_ch.position = '0;
        cmd_ch.word = '0;
        rsp_ch.ready = 1'b0;
        i_rst_n = 1'b0;

        add_cmd(CMD_READ, 0, 32'd0);
        add_cmd(CMD_ERASE, 0, 32'd0);
        add_cmd(CMD_POP_BACK, 0, 32'd0);
        add_cmd(CMD_POP_FRONT, 0, 32'd0);
        add_cmd(CMD_FIND, 0, 32'd0);
        add_cmd(CMD_INSERT, 1, 32'd7);
        add_cmd(CMD_PUSH_BACK, 0, 32'h7FFF_FFFF);
        add_cmd(CMD_PUSH_FRONT, 0, 32'h8000_0000);
        add_cmd(CMD_INSERT, 1, 32'h0000_0000);
        add_cmd(CMD_INSERT, 3, 32'hFFFF_FFFF);
        add_cmd(CMD_INSERT, 127, 32'd5);
        add_cmd(CMD_FIND, 0, 32'hFFFF_FFFF);
        add_cmd(CMD_FIND, 0, 32'h8000_0000);
        add_cmd(CMD_FIND, 0, 32'd12345);
        add_cmd(CMD_READ, 127, 32'd0);
        add_cmd(CMD_READ, 3, 32'd0);
        add_cmd(CMD_READ, 4, 32'd0);
        add_cmd(CMD_ERASE, 4, 32'd0);
        add_cmd(CMD_ERASE, 1, 32'd0);
        add_cmd(CMD_POP_BACK, 0, 32'd0);
        add_cmd(CMD_POP_FRONT, 0, 32'd0);
        add_cmd(CMD_POP_FRONT, 0, 32'd0);

        grow = 1'b1;
        edge_hits = 0;
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                add_cmd(t_cmd'($urandom_range(0, 7)), $urandom_range(0, 127), $urandom);
            end else if (r < 25) begin
                add_cmd(CMD_FIND, $urandom_range(0, 127), pick_word());
            end else if (r < 32) begin
                add_cmd(CMD_READ, pick_pos(1'b0), $urandom);
            end else if ($urandom_range(0, 99) < (grow ? 80 : 20)) begin
                r = $urandom_range(0, 2);
                c = (r == 0) ? CMD_INSERT : (r == 1 ? CMD_PUSH_BACK : CMD_PUSH_FRONT);
                add_cmd(c, pick_pos(1'b1), pick_word());
            end else begin
                r = $urandom_range(0, 2);
                c = (r == 0) ? CMD_ERASE : (r == 1 ? CMD_POP_BACK : CMD_POP_FRONT);
                add_cmd(c, pick_pos(1'b0), $urandom);
            end
            if (plan_len == (grow ? DEPTH : 0)) begin
                edge_hits++;
                if (edge_hits >= 4) begin
                    grow = !grow;
                    edge_hits = 0;
                end
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || drv_busy) @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (due_results.size() != 0) begin
            $display("%0t: %0d results still expected, actual none", $time, due_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/oile_pkg.sv
hdl/oile_cmd_if.sv
hdl/oile_rsp_if.sv
hdl/oile_ctrl.sv
hdl/oile_dpath.sv
hdl/ordered_int_list_engine_unit.sv
tb/sv/testbench.sv
